### design/mbrtu_pkg.sv
// Shared types, codes and the CRC-16 byte update for the Modbus RTU request parser.
package mbrtu_pkg;

   // Register indexes of the configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SILENT_LIMIT   = 1'd1;

   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd1;
   localparam logic [1:0] SILENT_LIMIT_RESET   = 2'd3;

   // Input item kinds
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_IDLE = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ILLEGAL = 2'd1;
   localparam logic [1:0] ST_CRC     = 2'd2;

   // Function codes with a known layout
   localparam logic [7:0] FUNC_READ_FIRST = 8'd1;
   localparam logic [7:0] FUNC_READ_LAST  = 8'd4;
   localparam logic [7:0] FUNC_WRITE_COIL = 8'd5;
   localparam logic [7:0] FUNC_WRITE_REG  = 8'd6;

   // Parse phases
   localparam int PHASE_W = 4;
   localparam logic [PHASE_W-1:0] PH_ADDR    = 4'd0;
   localparam logic [PHASE_W-1:0] PH_FUNC    = 4'd1;
   localparam logic [PHASE_W-1:0] PH_SADDR_H = 4'd2;
   localparam logic [PHASE_W-1:0] PH_SADDR_L = 4'd3;
   localparam logic [PHASE_W-1:0] PH_QTY_H   = 4'd4;
   localparam logic [PHASE_W-1:0] PH_QTY_L   = 4'd5;
   localparam logic [PHASE_W-1:0] PH_OADDR_H = 4'd6;
   localparam logic [PHASE_W-1:0] PH_OADDR_L = 4'd7;
   localparam logic [PHASE_W-1:0] PH_VAL_H   = 4'd8;
   localparam logic [PHASE_W-1:0] PH_VAL_L   = 4'd9;
   localparam logic [PHASE_W-1:0] PH_CRC_L   = 4'd10;
   localparam logic [PHASE_W-1:0] PH_CRC_H   = 4'd11;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } mbrtu_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  function_code;
      logic [15:0] reg_address;
      logic [15:0] quantity;
      logic [15:0] write_value;
   } mbrtu_rsp_type;

   // Reflected CRC-16 update over one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### design/mbrtu_in_stage.sv
// Input register of the request parser: holds one accepted item until the core takes it.
module mbrtu_in_stage
   import mbrtu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  mbrtu_req_type req_data,
   input  logic          take,
   output logic          item_valid,
   output mbrtu_req_type item_data
);

   logic          valid_ff, valid_in;
   mbrtu_req_type data_ff;
   logic          load;

   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

### design/mbrtu_parse_core.sv
// Frame state machine, CRC accumulator and held request fields of the parser.
module mbrtu_parse_core
   import mbrtu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          fire,
   input  mbrtu_req_type item_data,
   input  logic [7:0]    device_address,
   input  logic [1:0]    silent_limit,
   output logic          res_valid,
   output mbrtu_rsp_type res_data
);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [15:0]        crc_ff, crc_in;
   logic [1:0]         idle_ff, idle_in;
   logic [7:0]         crc_lo_ff, crc_lo_in;
   logic [7:0]         func_ff, func_in;
   logic [15:0]        addr_ff, addr_in;
   logic [15:0]        qty_ff, qty_in;
   logic [15:0]        value_ff, value_in;
   logic               feed;
   logic               restart;
   logic               is_read;
   logic [7:0]         b;

   assign b = item_data.data_byte;

   always_comb begin
      phase_in  = phase_ff;
      crc_in    = crc_ff;
      idle_in   = idle_ff;
      crc_lo_in = crc_lo_ff;
      func_in   = func_ff;
      addr_in   = addr_ff;
      qty_in    = qty_ff;
      value_in  = value_ff;
      feed      = 1'b0;
      restart   = 1'b0;
      is_read   = func_ff inside {[FUNC_READ_FIRST:FUNC_READ_LAST]};
      res_valid = 1'b0;
      res_data  = '0;

      if (fire) begin
         if (item_data.op == OP_IDLE) begin
            if (idle_ff >= silent_limit) begin
               restart = 1'b1;
            end else begin
               idle_in = idle_ff + 2'd1;
            end
         end else begin
            idle_in = 2'd0;
            case (phase_ff)
               PH_FUNC: begin
                  func_in = b;
                  if (b inside {[FUNC_READ_FIRST:FUNC_READ_LAST]}) begin
                     phase_in = PH_SADDR_H;
                     feed     = 1'b1;
                  end else if (b inside {FUNC_WRITE_COIL, FUNC_WRITE_REG}) begin
                     phase_in = PH_OADDR_H;
                     feed     = 1'b1;
                  end else begin
                     res_valid              = 1'b1;
                     res_data.status        = ST_ILLEGAL;
                     res_data.function_code = b;
                     restart                = 1'b1;
                  end
               end
               PH_SADDR_H: begin
                  addr_in  = {b, 8'd0};
                  phase_in = PH_SADDR_L;
                  feed     = 1'b1;
               end
               PH_OADDR_H: begin
                  addr_in  = {b, 8'd0};
                  phase_in = PH_OADDR_L;
                  feed     = 1'b1;
               end
               PH_SADDR_L: begin
                  addr_in  = {addr_ff[15:8], b};
                  phase_in = PH_QTY_H;
                  feed     = 1'b1;
               end
               PH_OADDR_L: begin
                  addr_in  = {addr_ff[15:8], b};
                  phase_in = PH_VAL_H;
                  feed     = 1'b1;
               end
               PH_QTY_H: begin
                  qty_in   = {b, 8'd0};
                  phase_in = PH_QTY_L;
                  feed     = 1'b1;
               end
               PH_QTY_L: begin
                  qty_in   = {qty_ff[15:8], b};
                  phase_in = PH_CRC_L;
                  feed     = 1'b1;
               end
               PH_VAL_H: begin
                  value_in = {b, 8'd0};
                  phase_in = PH_VAL_L;
                  feed     = 1'b1;
               end
               PH_VAL_L: begin
                  value_in = {value_ff[15:8], b};
                  phase_in = PH_CRC_L;
                  feed     = 1'b1;
               end
               PH_CRC_L: begin
                  crc_lo_in = b;
                  phase_in  = PH_CRC_H;
               end
               PH_CRC_H: begin
                  res_valid              = 1'b1;
                  res_data.status        = ({b, crc_lo_ff} == crc_ff) ? ST_OK : ST_CRC;
                  res_data.function_code = func_ff;
                  res_data.reg_address   = addr_ff;
                  res_data.quantity      = is_read ? qty_ff : 16'd0;
                  res_data.write_value   = is_read ? 16'd0 : value_ff;
                  restart                = 1'b1;
               end
               default: begin
                  // hunt for the device address; unused codes land here too
                  if (b == device_address) begin
                     phase_in = PH_FUNC;
                     feed     = 1'b1;
                  end else begin
                     phase_in = PH_ADDR;
                  end
               end
            endcase
         end

         if (feed) begin
            crc_in = crc_byte(crc_ff, b);
         end
         if (restart) begin
            phase_in = PH_ADDR;
            crc_in   = CRC_INIT;
            idle_in  = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ADDR;
         crc_ff   <= CRC_INIT;
         idle_ff  <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         crc_ff   <= crc_in;
         idle_ff  <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_lo_ff <= crc_lo_in;
      func_ff   <= func_in;
      addr_ff   <= addr_in;
      qty_ff    <= qty_in;
      value_ff  <= value_in;
   end

endmodule

### design/mbrtu_out_stage.sv
// Result register of the request parser: holds an item until the receiver takes it.
module mbrtu_out_stage
   import mbrtu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          res_valid,
   input  mbrtu_rsp_type res_data,
   output logic          ready,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output mbrtu_rsp_type rsp_data
);

   logic          valid_ff, valid_in;
   mbrtu_rsp_type data_ff;

   // free when empty or the held item leaves this cycle
   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (ready) begin
         valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && res_valid) begin
         data_ff <= res_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### design/modbus_rtu_request_parser_unit.sv
// Top level of the Modbus RTU request parser: configuration registers and the item pipeline.
//
// Usage:
//   req_* channel carries one item per handshake: a received byte (op = 0) or an
//   idle poll (op = 1). rsp_* channel carries a decoded request, an illegal
//   function report or a CRC mismatch report; most items give no result.
//   csr_* port writes device_address (index 0) and silent_limit (index 1);
//   write it only while no item is in flight.
// Path: an accepted item is held in the input register; one pass of the frame state
//   machine and byte-wide CRC update then writes any result into the output register.
// Throughput: one item per cycle unless rsp_stall holds a result; the CRC byte update is combinational.
// Reset: synchronous; empties both registers, returns the parser to hunting for
//   the device address and loads device_address = 1, silent_limit = 3.
// Stall: while rsp_stall holds a result in the output register the core takes no
//   item at all; req_stall rises while an item waits in the input register and is not taken.
module modbus_rtu_request_parser_unit
   import mbrtu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mbrtu_req_type          req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mbrtu_rsp_type          rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [7:0]    device_address_ff;
   logic [1:0]    silent_limit_ff;
   logic          item_valid;
   mbrtu_req_type item_data;
   logic          out_ready;
   logic          take;
   logic          res_valid;
   mbrtu_rsp_type res_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= DEVICE_ADDRESS_RESET;
         silent_limit_ff   <= SILENT_LIMIT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS: device_address_ff <= csr_wdata[7:0];
            CSR_SILENT_LIMIT:   silent_limit_ff   <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   // take an item only when its result, if any, has room
   assign take = item_valid && out_ready;

   mbrtu_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .take       (take),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   mbrtu_parse_core u_parse_core (
      .clock          (clock),
      .reset          (reset),
      .fire           (take),
      .item_data      (item_data),
      .device_address (device_address_ff),
      .silent_limit   (silent_limit_ff),
      .res_valid      (res_valid),
      .res_data       (res_data)
   );

   mbrtu_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_data  (res_data),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### design/mbrtu_checker.sv
// Port-level assertions for the Modbus RTU request parser, bound to the top level.
module mbrtu_checker
   import mbrtu_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input mbrtu_rsp_type rsp_data
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present straight after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_OK || rsp_data.status == ST_ILLEGAL ||
                     rsp_data.status == ST_CRC))
      else $error("unknown status code");

   a_illegal_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_ILLEGAL |->
         rsp_data.reg_address == 16'd0 && rsp_data.quantity == 16'd0 &&
         rsp_data.write_value == 16'd0)
      else $error("illegal function result carries payload");

   a_fields_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_ILLEGAL |->
         rsp_data.quantity == 16'd0 || rsp_data.write_value == 16'd0)
      else $error("quantity and write value both set");

endmodule

bind modbus_rtu_request_parser_unit mbrtu_checker u_mbrtu_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
